// ===== rtl/rcqp_pkg.sv =====
package rcqp_pkg;

	localparam int RCQP_QUEUE_DEPTH   = 16;
	localparam int RCQP_PAYLOAD_BYTES = 8;
	localparam int PAYLOAD_W          = 64;
	localparam int TIME_W             = 32;
	localparam int INTERVAL_W         = 16;
	localparam int LEN_W              = 4;
	localparam int CFG_INDEX_W        = 2;
	localparam int CFG_DATA_W         = 16;

	typedef logic [2:0] status_t;
	typedef logic [1:0] mode_t;
	typedef logic [7:0] byte_t;

	// result status codes
	localparam status_t ST_QUEUED   = 3'd0;
	localparam status_t ST_DUP      = 3'd1;
	localparam status_t ST_FULL     = 3'd2;
	localparam status_t ST_DISABLED = 3'd3;
	localparam status_t ST_NOSEND   = 3'd4;
	localparam status_t ST_SENT     = 3'd5;

	// item kinds
	localparam logic CMD_SUBMIT = 1'b0;
	localparam logic CMD_POLL   = 1'b1;

	// last-byte rules
	localparam mode_t MODE_NONE     = 2'd0;
	localparam mode_t MODE_SUBTRACT = 2'd1;
	localparam mode_t MODE_NIBBLE   = 2'd2;

	// configuration register indexes
	localparam logic [CFG_INDEX_W-1:0] CFG_TX_ENABLE     = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_ENCODING_MODE = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_SEND_INTERVAL = 2'd2;
	localparam logic [CFG_INDEX_W-1:0] CFG_DATA_LEN      = 2'd3;

	localparam logic [LEN_W-1:0] DATA_LEN_RESET = 4'd8;

	// last-byte rule constants
	localparam byte_t GROUP_STEP = 8'h10;
	localparam byte_t SUB_BASE   = 8'h3C;
	localparam byte_t SUB_STEP   = 8'h11;
	localparam byte_t NIB_KEEP   = 8'hF0;
	localparam byte_t NIB_BIT    = 8'h08;

	// queue occupancy flags
	typedef struct packed {
		logic empty;
		logic full;
	} q_stat_t;

endpackage

// ===== rtl/rcqp_if.sv =====
interface rcqp_in_if;
	import rcqp_pkg::*;

	logic                 valid;
	logic                 ready;
	logic                 command;
	byte_t                cmd_code;
	byte_t                group_id;
	logic [PAYLOAD_W-1:0] payload;
	logic [TIME_W-1:0]    now_ms;

	modport source (output valid, command, cmd_code, group_id, payload, now_ms, input ready);
	modport sink (input valid, command, cmd_code, group_id, payload, now_ms, output ready);
endinterface

interface rcqp_out_if;
	import rcqp_pkg::*;

	logic                 valid;
	logic                 ready;
	status_t              status;
	logic [PAYLOAD_W-1:0] frame;
	logic                 repeat_no;

	modport source (output valid, status, frame, repeat_no, input ready);
	modport sink (input valid, status, frame, repeat_no, output ready);
endinterface

// ===== rtl/rcqp_queue.sv =====
module rcqp_queue #(
	parameter int DEPTH = rcqp_pkg::RCQP_QUEUE_DEPTH,
	parameter int PLD_W = 8 * rcqp_pkg::RCQP_PAYLOAD_BYTES
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  rcqp_pkg::byte_t   push_code,
	input  rcqp_pkg::byte_t   push_group,
	input  logic [PLD_W-1:0]  push_payload,
	input  logic              pop,
	output rcqp_pkg::q_stat_t stat,
	output rcqp_pkg::byte_t   head_code,
	output rcqp_pkg::byte_t   head_group,
	output logic [PLD_W-1:0]  head_payload,
	output rcqp_pkg::byte_t   new_code,
	output rcqp_pkg::byte_t   new_group,
	output logic [PLD_W-1:0]  new_payload
);
	import rcqp_pkg::*;

	localparam int PTR_W = $clog2(DEPTH);
	localparam int ENT_W = 16 + PLD_W;

	logic [ENT_W-1:0] mem [DEPTH];
	logic [PTR_W-1:0] head_q, tail_q, head_nx, tail_inc, head_inc;
	logic [ENT_W-1:0] wr_entry, head_entry_q;
	logic [ENT_W-1:0] newest_q;

	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		logic [PTR_W-1:0] r;
		if (p == PTR_W'(DEPTH - 1)) begin
			r = '0;
		end else begin
			r = p + 1'b1;
		end
		return r;
	endfunction

	assign tail_inc   = ptr_inc(tail_q);
	assign head_inc   = ptr_inc(head_q);
	assign head_nx    = pop ? head_inc : head_q;
	assign wr_entry   = {push_code, push_group, push_payload};
	assign stat.empty = (head_q == tail_q);
	assign stat.full  = (tail_inc == head_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
		end else begin
			if (push) begin
				tail_q <= tail_inc;
			end
			if (pop) begin
				head_q <= head_inc;
			end
		end
	end

	// storage with a registered read of the next head entry; write-through
	// when the slot being written becomes the head
	always_ff @(posedge clk) begin
		if (push) begin
			mem[tail_q] <= wr_entry;
			newest_q    <= wr_entry;
		end
		if (push && tail_q == head_nx) begin
			head_entry_q <= wr_entry;
		end else begin
			head_entry_q <= mem[head_nx];
		end
	end

	assign head_code    = head_entry_q[ENT_W-1 -: 8];
	assign head_group   = head_entry_q[ENT_W-9 -: 8];
	assign head_payload = head_entry_q[PLD_W-1:0];
	assign new_code     = newest_q[ENT_W-1 -: 8];
	assign new_group    = newest_q[ENT_W-9 -: 8];
	assign new_payload  = newest_q[PLD_W-1:0];

endmodule

// ===== rtl/rf_command_queue_pacer.sv =====
// Command queue that paces radio frames. A submit transaction (command 0)
// offers a code, a group and a payload; with tx_enable set it is queued in a
// ring of QUEUE_DEPTH slots (one slot always stays free), unless the queue is
// full or it repeats the newest queued entry on code, group and the first
// active (clamped data_len) payload bytes. A poll transaction (command 1) carries the time in
// milliseconds; when no frame is in flight it pops the oldest entry, adjusts
// its last active byte by encoding_mode and then sends that frame twice, each
// send once send_interval ms have passed since the pop or the first send.
// Every input transaction gives exactly one result transaction. An item passes
// through the input register and then the result register, and a new item is
// taken every cycle as long as the result side keeps taking results; the queue
// memory is read one head entry ahead, so the pop never waits on a memory read.
// Configuration is written through cfg_we/cfg_index/cfg_data; the user must
// write it only while no item is in flight, as the block does not enforce this.
module rf_command_queue_pacer #(
	parameter int QUEUE_DEPTH   = rcqp_pkg::RCQP_QUEUE_DEPTH,
	parameter int PAYLOAD_BYTES = rcqp_pkg::RCQP_PAYLOAD_BYTES
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [rcqp_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  logic [rcqp_pkg::CFG_DATA_W-1:0]      cfg_data,
	rcqp_in_if.sink                              in_ch,
	rcqp_out_if.source                           out_ch
);
	import rcqp_pkg::*;

	localparam int PLD_W = 8 * PAYLOAD_BYTES;
	localparam int IDX_W = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1;

	// configuration registers
	logic                  tx_enable_q;
	mode_t                 encoding_mode_q;
	logic [INTERVAL_W-1:0] send_interval_q;
	logic [LEN_W-1:0]      data_len_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tx_enable_q     <= 1'b0;
			encoding_mode_q <= MODE_NONE;
			send_interval_q <= '0;
			data_len_q      <= DATA_LEN_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_TX_ENABLE:     tx_enable_q     <= cfg_data[0];
				CFG_ENCODING_MODE: encoding_mode_q <= cfg_data[1:0];
				CFG_SEND_INTERVAL: send_interval_q <= cfg_data[INTERVAL_W-1:0];
				CFG_DATA_LEN:      data_len_q      <= cfg_data[LEN_W-1:0];
				default: ;
			endcase
		end
	end

	// input register stage
	logic                  valid_s1;
	logic                  command_s1;
	byte_t                 code_s1, group_s1;
	logic [PLD_W-1:0]      payload_s1;
	logic [TIME_W-1:0]     now_s1;

	// result register stage
	logic                  valid_s2;
	status_t               status_s2;
	logic [PLD_W-1:0]      frame_s2;
	logic                  rep_s2;

	logic advance, process;

	// result slot frees when empty or when its transaction completes
	assign advance     = !valid_s2 || out_ch.ready;
	assign process     = valid_s1 && advance;
	assign in_ch.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			command_s1 <= in_ch.command;
			code_s1    <= in_ch.cmd_code;
			group_s1   <= in_ch.group_id;
			payload_s1 <= in_ch.payload[PLD_W-1:0];
			now_s1     <= in_ch.now_ms;
		end
	end

	// active length, clamped to 1..PAYLOAD_BYTES, and its byte mask
	logic [LEN_W-1:0] act_len;
	logic [IDX_W-1:0] last_idx;
	logic [PLD_W-1:0] len_mask;

	always_comb begin
		if (data_len_q == '0) begin
			act_len = LEN_W'(1);
		end else if (data_len_q > LEN_W'(PAYLOAD_BYTES)) begin
			act_len = LEN_W'(PAYLOAD_BYTES);
		end else begin
			act_len = data_len_q;
		end
	end

	assign last_idx = IDX_W'(act_len - 1'b1);

	always_comb begin
		for (int i = 0; i < PAYLOAD_BYTES; i++) begin
			len_mask[8*i +: 8] = (LEN_W'(i) < act_len) ? 8'hFF : 8'h00;
		end
	end

	// queue
	q_stat_t          q_stat;
	byte_t            head_code, head_group, new_code, new_group;
	logic [PLD_W-1:0] head_payload, new_payload, pl_masked;
	logic             push, pop;

	assign pl_masked = payload_s1 & len_mask;

	rcqp_queue #(
		.DEPTH (QUEUE_DEPTH),
		.PLD_W (PLD_W)
	) u_queue (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.push_code    (code_s1),
		.push_group   (group_s1),
		.push_payload (pl_masked),
		.pop          (pop),
		.stat         (q_stat),
		.head_code    (head_code),
		.head_group   (head_group),
		.head_payload (head_payload),
		.new_code     (new_code),
		.new_group    (new_group),
		.new_payload  (new_payload)
	);

	// last-byte rule on the popped entry
	logic [PLD_W-1:0] pop_data, pop_frame;
	byte_t            last_b, adj_b, t_lo, sub_k, sub_prod, nib_add;
	logic [15:0]      t_full;

	assign pop_data = head_payload & len_mask;

	always_comb begin
		last_b = '0;
		for (int i = 0; i < PAYLOAD_BYTES; i++) begin
			if (last_idx == IDX_W'(i)) begin
				last_b = pop_data[8*i +: 8];
			end
		end
	end

	// t is code minus 16 * group, taken mod 2^16
	assign t_full   = {8'h00, head_code} - 16'(head_group) * 16'(GROUP_STEP);
	assign t_lo     = t_full[7:0];
	assign sub_k    = 8'd3 - t_lo;
	assign sub_prod = 8'(sub_k * SUB_STEP);
	assign nib_add  = (t_full < 16'd4) ? (NIB_BIT >> t_full[1:0]) : 8'h00;

	always_comb begin
		unique case (encoding_mode_q)
			MODE_SUBTRACT: adj_b = last_b - SUB_BASE - sub_prod;
			MODE_NIBBLE:   adj_b = (last_b & NIB_KEEP) + nib_add;
			default:       adj_b = last_b;
		endcase
	end

	always_comb begin
		pop_frame = pop_data;
		for (int i = 0; i < PAYLOAD_BYTES; i++) begin
			if (last_idx == IDX_W'(i)) begin
				pop_frame[8*i +: 8] = adj_b;
			end
		end
	end

	// send pacing state
	logic              sending_q, step_q;
	logic [TIME_W-1:0] last_send_q;
	logic [PLD_W-1:0]  frame_buf_q;

	logic              is_poll, is_submit, dup_hit;
	logic              snd_c, step_c, send_ok;
	logic [TIME_W-1:0] last_c, elapsed;
	logic [PLD_W-1:0]  fbuf_c;
	status_t           status_c;

	assign is_poll   = process && command_s1 == CMD_POLL;
	assign is_submit = process && command_s1 == CMD_SUBMIT;

	// repeat of the newest queued entry on code, group and active bytes
	assign dup_hit = !q_stat.empty && new_code == code_s1 && new_group == group_s1
	                 && ((new_payload ^ pl_masked) & len_mask) == '0;

	assign push = is_submit && tx_enable_q && !q_stat.full && !dup_hit;
	assign pop  = is_poll && !q_stat.empty && !sending_q;

	// a pop restarts the interval at the current time
	assign snd_c   = pop ? 1'b1 : sending_q;
	assign step_c  = pop ? 1'b0 : step_q;
	assign last_c  = pop ? now_s1 : last_send_q;
	assign fbuf_c  = pop ? pop_frame : frame_buf_q;
	assign elapsed = now_s1 - last_c;
	assign send_ok = snd_c && elapsed >= TIME_W'(send_interval_q);

	always_comb begin
		if (command_s1 == CMD_POLL) begin
			status_c = send_ok ? ST_SENT : ST_NOSEND;
		end else begin
			priority if (!tx_enable_q) begin
				status_c = ST_DISABLED;
			end else if (q_stat.full) begin
				status_c = ST_FULL;
			end else if (dup_hit) begin
				status_c = ST_DUP;
			end else begin
				status_c = ST_QUEUED;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sending_q   <= 1'b0;
			step_q      <= 1'b0;
			last_send_q <= '0;
			frame_buf_q <= '0;
		end else if (is_poll) begin
			frame_buf_q <= fbuf_c;
			if (send_ok) begin
				if (!step_c) begin
					sending_q   <= 1'b1;
					step_q      <= 1'b1;
					last_send_q <= now_s1;
				end else begin
					sending_q   <= 1'b0;
					step_q      <= step_c;
					last_send_q <= last_c;
				end
			end else begin
				sending_q   <= snd_c;
				step_q      <= step_c;
				last_send_q <= last_c;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (process) begin
			status_s2 <= status_c;
			if (is_poll && send_ok) begin
				frame_s2 <= fbuf_c & len_mask;
				rep_s2   <= step_c;
			end else begin
				frame_s2 <= '0;
				rep_s2   <= 1'b0;
			end
		end
	end

	assign out_ch.valid     = valid_s2;
	assign out_ch.status    = status_s2;
	assign out_ch.frame     = PAYLOAD_W'(frame_s2);
	assign out_ch.repeat_no = rep_s2;

endmodule
